[sv/annulus_deviation_score_core_defines.svh]
// Assertion macros shared by the annulus deviation score RTL.
`ifndef ANNULUS_DEVIATION_SCORE_CORE_DEFINES_SVH
`define ANNULUS_DEVIATION_SCORE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define ADSC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("adsc: same-cycle check failed");

// Next-cycle implication.
`define ADSC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("adsc: next-cycle check failed");

`else

`define ADSC_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define ADSC_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

[sv/adsc_pkg.sv]
package adsc_pkg;

   localparam int REG_W     = 24;
   localparam int SCORE_W   = 48;
   localparam int SUM_W     = 64;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_INNER_RADIUS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTER_RADIUS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIGMA        = 2'd2;

   localparam logic [REG_W-1:0]   INNER_RESET = 24'd0;
   localparam logic [REG_W-1:0]   OUTER_RESET = 24'hFFFFFF;
   localparam logic [REG_W-1:0]   SIGMA_RESET = 24'd256;
   localparam logic [SCORE_W-1:0] SCORE_MAX   = 48'hFFFF_FFFF_FFFF;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQX,
      ST_SQY,
      ST_SQI,
      ST_SQO,
      ST_CMP,
      ST_ROOT,
      ST_DIFF,
      ST_SQD,
      ST_ACC,
      ST_DCHK,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

[sv/adsc_sub_unit.sv]
module adsc_sub_unit #(
   parameter int WIDTH = 25
) (
   input  logic [WIDTH-1:0] minuend,
   input  logic [WIDTH-1:0] subtrahend,
   output logic             ge,
   output logic [WIDTH-1:0] diff
);

   logic [WIDTH:0] full;

   assign full = {1'b0, minuend} - {1'b0, subtrahend};
   assign ge   = ~full[WIDTH];
   assign diff = full[WIDTH-1:0];

endmodule

[sv/adsc_mul.sv]
module adsc_mul #(
   parameter int WIDTH = 24
) (
   input  logic               clock,
   input  logic [WIDTH-1:0]   op_a,
   input  logic [WIDTH-1:0]   op_b,
   output logic [2*WIDTH-1:0] product
);

   logic [2*WIDTH-1:0] product_ff;

   always_ff @(posedge clock) begin
      product_ff <= op_a * op_b;
   end

   assign product = product_ff;

endmodule

[sv/annulus_deviation_score_core.sv]
// Annulus deviation score. Each req beat carries one particle (x, y); the core adds the squared
// distance of the particle from the annulus [inner_radius, outer_radius] to a saturating 64-bit
// sum, and on the beat with tlast set it returns sum / sigma (48 bits, 8 fraction bits) with a
// saturation flag, then clears the sum. One item is in flight at a time: a particle inside the
// annulus skips the square root, while one off the annulus waits for the bit-serial square root
// that produces one root bit per cycle on the shared subtractor. A last beat adds the 48-step
// restoring divide on the same subtractor (skipped when sigma is zero or the quotient
// saturates), and the core then holds the score while an earlier score still waits unaccepted.
// One multiplier is shared for all squares. The finished score sits in an output register, so
// the next item is accepted while it waits.
`include "annulus_deviation_score_core_defines.svh"

module annulus_deviation_score_core
   import adsc_pkg::*;
#(
   parameter int COORD_WIDTH = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // coord_x, coord_y, zero fill
   input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]      req_tdata,
   input  logic                                   req_tlast,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // score
   output logic [SCORE_W-1:0]                     rsp_tdata,
   // saturated
   output logic                                   rsp_tuser,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [CSR_IDX_W-1:0]                   csr_index,
   input  logic [REG_W-1:0]                       csr_data
);

   localparam int W     = COORD_WIDTH;
   localparam int MW    = (W > REG_W) ? W : REG_W;
   localparam int PW    = 2 * MW;
   localparam int RW    = 2 * W;
   localparam int UW    = (W + 3 > REG_W + 1) ? W + 3 : REG_W + 1;
   localparam int STEPS = (W > SCORE_W) ? W : SCORE_W;
   localparam int CNT_W = $clog2(STEPS + 1);

   state_type            state_ff, state_in;
   logic [REG_W-1:0]     inner_ff, inner_in;
   logic [REG_W-1:0]     outer_ff, outer_in;
   logic [REG_W-1:0]     sigma_ff, sigma_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic                 ovf_ff, ovf_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [W-1:0]         ax_ff, ax_in;
   logic [W-1:0]         ay_ff, ay_in;
   logic                 last_ff, last_in;
   logic [RW-1:0]        radial_ff, radial_in;
   logic [PW-1:0]        inner_sq_ff, inner_sq_in;
   logic                 in_inner_ff, in_inner_in;
   logic                 has_dev_ff, has_dev_in;
   logic [W-1:0]         root_ff, root_in;
   logic [UW-1:0]        rem_ff, rem_in;
   logic [MW-1:0]        diff_ff, diff_in;
   logic [SCORE_W-1:0]   quo_ff, quo_in;
   logic                 sat_ff, sat_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [SCORE_W-1:0]   rsp_score_ff, rsp_score_in;
   logic                 rsp_sat_ff, rsp_sat_in;

   logic [W-1:0]         x_raw, y_raw, x_mag, y_mag;
   logic [MW-1:0]        mul_a;
   logic [PW-1:0]        product;
   logic [UW-1:0]        sub_a, sub_b, sub_diff;
   logic                 sub_ge;
   logic                 in_inner, out_outer;
   logic [SUM_W:0]       sum_add;
   logic                 out_free;
   logic                 done_fire;

   assign x_raw = req_tdata[W-1:0];
   assign y_raw = req_tdata[2*W-1:W];
   assign x_mag = x_raw[W-1] ? (~x_raw + W'(1)) : x_raw;
   assign y_mag = y_raw[W-1] ? (~y_raw + W'(1)) : y_raw;

   assign in_inner  = PW'(radial_ff) < inner_sq_ff;
   assign out_outer = PW'(radial_ff) > product;
   assign sum_add   = {1'b0, sum_ff} + {1'b0, (has_dev_ff ? SUM_W'(product) : SUM_W'(0))};
   assign out_free  = ~rsp_valid_ff | rsp_tready;
   assign done_fire = (state_ff == ST_DONE) & out_free;

   adsc_mul #(.WIDTH(MW)) u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_a),
      .product (product)
   );

   adsc_sub_unit #(.WIDTH(UW)) u_sub (
      .minuend    (sub_a),
      .subtrahend (sub_b),
      .ge         (sub_ge),
      .diff       (sub_diff)
   );

   always_comb begin
      state_in     = state_ff;
      inner_in     = inner_ff;
      outer_in     = outer_ff;
      sigma_in     = sigma_ff;
      sum_in       = sum_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      last_in      = last_ff;
      radial_in    = radial_ff;
      inner_sq_in  = inner_sq_ff;
      in_inner_in  = in_inner_ff;
      has_dev_in   = has_dev_ff;
      root_in      = root_ff;
      rem_in       = rem_ff;
      diff_in      = diff_ff;
      quo_in       = quo_ff;
      sat_in       = sat_ff;
      cnt_in       = cnt_ff;
      rsp_score_in = rsp_score_ff;
      rsp_sat_in   = rsp_sat_ff;
      mul_a        = MW'(ax_ff);
      sub_a        = UW'({rem_ff[UW-3:0], radial_ff[RW-1:RW-2]});
      sub_b        = UW'({root_ff, 2'b01});

      if (csr_valid) begin
         unique case (csr_index)
            CSR_INNER_RADIUS: inner_in = csr_data;
            CSR_OUTER_RADIUS: outer_in = csr_data;
            CSR_SIGMA:        sigma_in = csr_data;
            default:          ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               ax_in    = x_mag;
               ay_in    = y_mag;
               last_in  = req_tlast;
               state_in = ST_SQX;
            end
         end
         ST_SQX: begin
            mul_a    = MW'(ax_ff);
            state_in = ST_SQY;
         end
         ST_SQY: begin
            radial_in = product[RW-1:0];
            mul_a     = MW'(ay_ff);
            state_in  = ST_SQI;
         end
         ST_SQI: begin
            radial_in = radial_ff + product[RW-1:0];
            mul_a     = MW'(inner_ff);
            state_in  = ST_SQO;
         end
         ST_SQO: begin
            inner_sq_in = product;
            mul_a       = MW'(outer_ff);
            state_in    = ST_CMP;
         end
         ST_CMP: begin
            in_inner_in = in_inner;
            has_dev_in  = in_inner | out_outer;
            rem_in      = '0;
            root_in     = '0;
            cnt_in      = CNT_W'(W);
            state_in    = (in_inner | out_outer) ? ST_ROOT : ST_ACC;
         end
         ST_ROOT: begin
            // one root bit per step, two radicand bits shifted in
            rem_in    = sub_ge ? sub_diff : sub_a;
            root_in   = {root_ff[W-2:0], sub_ge};
            radial_in = {radial_ff[RW-3:0], 2'b00};
            cnt_in    = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            sub_a    = in_inner_ff ? UW'(inner_ff) : UW'(root_ff);
            sub_b    = in_inner_ff ? UW'(root_ff) : UW'(outer_ff);
            diff_in  = sub_diff[MW-1:0];
            state_in = ST_SQD;
         end
         ST_SQD: begin
            mul_a    = diff_ff;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (sum_add[SUM_W]) begin
               sum_in = '1;
               ovf_in = 1'b1;
            end else begin
               sum_in = sum_add[SUM_W-1:0];
            end
            state_in = last_ff ? ST_DCHK : ST_IDLE;
         end
         ST_DCHK: begin
            if ((sigma_ff == '0) || (REG_W'(sum_ff[SUM_W-1:SCORE_W]) >= sigma_ff)) begin
               quo_in   = SCORE_MAX;
               sat_in   = 1'b1;
               state_in = ST_DONE;
            end else begin
               sat_in   = ovf_ff;
               rem_in   = UW'(sum_ff[SUM_W-1:SCORE_W]);
               quo_in   = sum_ff[SCORE_W-1:0];
               cnt_in   = CNT_W'(SCORE_W);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            sub_a  = UW'({rem_ff[REG_W-1:0], quo_ff[SCORE_W-1]});
            sub_b  = UW'(sigma_ff);
            rem_in = sub_ge ? sub_diff : sub_a;
            quo_in = {quo_ff[SCORE_W-2:0], sub_ge};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (done_fire) begin
               rsp_valid_in = 1'b1;
               rsp_score_in = quo_ff;
               rsp_sat_in   = sat_ff;
               sum_in       = '0;
               ovf_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         inner_ff     <= INNER_RESET;
         outer_ff     <= OUTER_RESET;
         sigma_ff     <= SIGMA_RESET;
         sum_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         inner_ff     <= inner_in;
         outer_ff     <= outer_in;
         sigma_ff     <= sigma_in;
         sum_ff       <= sum_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff        <= ax_in;
      ay_ff        <= ay_in;
      last_ff      <= last_in;
      radial_ff    <= radial_in;
      inner_sq_ff  <= inner_sq_in;
      in_inner_ff  <= in_inner_in;
      has_dev_ff   <= has_dev_in;
      root_ff      <= root_in;
      rem_ff       <= rem_in;
      diff_ff      <= diff_in;
      quo_ff       <= quo_in;
      sat_ff       <= sat_in;
      cnt_ff       <= cnt_in;
      rsp_score_ff <= rsp_score_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_score_ff;
   assign rsp_tuser  = rsp_sat_ff;

   `ADSC_ASSERT_NOW(a_div_rem_ok, clock, reset, state_ff == ST_DIV, rem_ff < UW'(sigma_ff))
   `ADSC_ASSERT_NOW(a_ovf_means_sum_full, clock, reset, ovf_ff, &sum_ff)
   `ADSC_ASSERT_NXT(a_done_clear, clock, reset, done_fire, rsp_valid_ff && ~|sum_ff && !ovf_ff)

endmodule
